// ----- src/yafp_pkg.sv -----
// Package for the YUV alpha fade pixel pipeline: pixel types, Q16 coefficients, clamp helper.
`default_nettype none
package yafp_pkg;

	typedef struct packed {
		logic [7:0] cr;
		logic [7:0] cb;
		logic [7:0] luma;
	} ycc_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} rgb_t;

	localparam int SumW = 27;

	localparam logic signed [SumW-1:0] K_Y  = 27'sd76309;
	localparam logic signed [SumW-1:0] K_RV = 27'sd104597;
	localparam logic signed [SumW-1:0] K_GU = -27'sd25675;
	localparam logic signed [SumW-1:0] K_GV = -27'sd53279;
	localparam logic signed [SumW-1:0] K_BU = 27'sd132201;

	localparam int BackW = 25;

	localparam logic signed [BackW-1:0] K_YR = 25'sd16829;
	localparam logic signed [BackW-1:0] K_YG = 25'sd33039;
	localparam logic signed [BackW-1:0] K_YB = 25'sd6416;
	localparam logic signed [BackW-1:0] K_UR = -25'sd9714;
	localparam logic signed [BackW-1:0] K_UG = -25'sd19071;
	localparam logic signed [BackW-1:0] K_UB = 25'sd28784;
	localparam logic signed [BackW-1:0] K_VR = 25'sd28784;
	localparam logic signed [BackW-1:0] K_VG = -25'sd24103;
	localparam logic signed [BackW-1:0] K_VB = -25'sd4681;

	localparam logic signed [BackW-1:0] OFS_Y = 25'sd1048576;
	localparam logic signed [BackW-1:0] OFS_C = 25'sd8388608;

	// Drop the fraction of a Q16 sum and clamp it to 0..255.
	function automatic logic [7:0] clamp_q16(input logic signed [SumW-1:0] q);
		logic [7:0] res;
		if (q[SumW-1]) begin
			res = 8'd0;
		end else if (q[SumW-2:24] != '0) begin
			res = 8'd255;
		end else begin
			res = q[23:16];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- src/yafp_yuv2rgb.sv -----
// YCbCr to RGB conversion in two pipeline stages: products, then sums and clamp.
`default_nettype none
module yafp_yuv2rgb
	import yafp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire ycc_t in_pix,
	output logic      out_valid,
	output rgb_t      out_pix,
	output logic      mid_valid
);

	logic signed [8:0]      y_d, u_d, v_d;
	logic signed [SumW-1:0] y_x, u_x, v_x;
	logic signed [SumW-1:0] p_y_s1, p_rv_s1, p_gu_s1, p_gv_s1, p_bu_s1;
	logic                   valid_s1, valid_s2;
	logic signed [SumW-1:0] sum_r, sum_g, sum_b;
	rgb_t                   rgb_s2;

	assign y_d = $signed({1'b0, in_pix.luma}) - 9'sd16;
	assign u_d = $signed({1'b0, in_pix.cb}) - 9'sd128;
	assign v_d = $signed({1'b0, in_pix.cr}) - 9'sd128;
	assign y_x = SumW'(y_d);
	assign u_x = SumW'(u_d);
	assign v_x = SumW'(v_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_y_s1  <= y_x * K_Y;
			p_rv_s1 <= v_x * K_RV;
			p_gu_s1 <= u_x * K_GU;
			p_gv_s1 <= v_x * K_GV;
			p_bu_s1 <= u_x * K_BU;
		end
	end

	assign sum_r = p_y_s1 + p_rv_s1;
	assign sum_g = p_y_s1 + p_gu_s1 + p_gv_s1;
	assign sum_b = p_y_s1 + p_bu_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s2.r <= clamp_q16(sum_r);
			rgb_s2.g <= clamp_q16(sum_g);
			rgb_s2.b <= clamp_q16(sum_b);
		end
	end

	assign out_valid = valid_s2;
	assign out_pix   = rgb_s2;
	assign mid_valid = valid_s1;

endmodule
`default_nettype wire

// ----- src/yafp_fade.sv -----
// Fade stage: scale each RGB channel by level / 256, floored.
`default_nettype none
module yafp_fade
	import yafp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [7:0] level,
	input  wire logic       in_valid,
	input  wire rgb_t       in_pix,
	output logic            out_valid,
	output rgb_t            out_pix
);

	logic [15:0] prod_r, prod_g, prod_b;
	logic        valid_s3;
	rgb_t        rgb_s3;

	assign prod_r = level * in_pix.r;
	assign prod_g = level * in_pix.g;
	assign prod_b = level * in_pix.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s3.r <= prod_r[15:8];
			rgb_s3.g <= prod_g[15:8];
			rgb_s3.b <= prod_b[15:8];
		end
	end

	assign out_valid = valid_s3;
	assign out_pix   = rgb_s3;

endmodule
`default_nettype wire

// ----- src/yafp_rgb2yuv.sv -----
// RGB to YCbCr conversion in two pipeline stages: products, then offset sums and clamp.
`default_nettype none
module yafp_rgb2yuv
	import yafp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire rgb_t in_pix,
	output logic      out_valid,
	output ycc_t      out_pix,
	output logic      mid_valid
);

	logic signed [BackW-1:0] r_x, g_x, b_x;
	logic signed [BackW-1:0] p_yr_s4, p_yg_s4, p_yb_s4;
	logic signed [BackW-1:0] p_ur_s4, p_ug_s4, p_ub_s4;
	logic signed [BackW-1:0] p_vr_s4, p_vg_s4, p_vb_s4;
	logic                    valid_s4, valid_s5;
	logic signed [BackW-1:0] sum_y, sum_u, sum_v;
	ycc_t                    ycc_s5;

	assign r_x = $signed({{(BackW-8){1'b0}}, in_pix.r});
	assign g_x = $signed({{(BackW-8){1'b0}}, in_pix.g});
	assign b_x = $signed({{(BackW-8){1'b0}}, in_pix.b});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_yr_s4 <= r_x * K_YR;
			p_yg_s4 <= g_x * K_YG;
			p_yb_s4 <= b_x * K_YB;
			p_ur_s4 <= r_x * K_UR;
			p_ug_s4 <= g_x * K_UG;
			p_ub_s4 <= b_x * K_UB;
			p_vr_s4 <= r_x * K_VR;
			p_vg_s4 <= g_x * K_VG;
			p_vb_s4 <= b_x * K_VB;
		end
	end

	assign sum_y = p_yr_s4 + p_yg_s4 + p_yb_s4 + OFS_Y;
	assign sum_u = p_ur_s4 + p_ug_s4 + p_ub_s4 + OFS_C;
	assign sum_v = p_vr_s4 + p_vg_s4 + p_vb_s4 + OFS_C;

	always_ff @(posedge clk) begin
		if (en) begin
			ycc_s5.luma <= clamp_q16(SumW'(sum_y));
			ycc_s5.cb   <= clamp_q16(SumW'(sum_u));
			ycc_s5.cr   <= clamp_q16(SumW'(sum_v));
		end
	end

	assign out_valid = valid_s5;
	assign out_pix   = ycc_s5;
	assign mid_valid = valid_s4;

endmodule
`default_nettype wire

// ----- src/yuv_alpha_fade_pixel.sv -----
// Top level of the YUV alpha fade pixel pipeline.
// An accepted input beat passes through the registered stages s1, s2, s3, s4 and s5 on its way to the output.
// Throughput: one pixel per cycle; the whole pipeline holds while an output beat waits.
// Reset: arst_n clears all stage valid bits and sets the fade level to 255.
`default_nettype none
module yuv_alpha_fade_pixel
	import yafp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,   // fade_level
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,    // luma_in, cb_in, cr_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata     // luma_out, cb_out, cr_out
);

	logic [7:0] fade_q;
	logic       adv;
	logic       v1, v2, v3, v4;
	rgb_t       rgb_conv, rgb_faded;
	ycc_t       ycc_out;

	// Advance the whole pipeline unless a finished beat is held at the output.
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q <= 8'd255;
		end else if (cfg_valid) begin
			fade_q <= cfg_data;
		end
	end

	yafp_yuv2rgb u_yuv2rgb (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.in_pix    (ycc_t'(s_tdata)),
		.out_valid (v2),
		.out_pix   (rgb_conv),
		.mid_valid (v1)
	);

	yafp_fade u_fade (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.level     (fade_q),
		.in_valid  (v2),
		.in_pix    (rgb_conv),
		.out_valid (v3),
		.out_pix   (rgb_faded)
	);

	yafp_rgb2yuv u_rgb2yuv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v3),
		.in_pix    (rgb_faded),
		.out_valid (m_tvalid),
		.out_pix   (ycc_out),
		.mid_valid (v4)
	);

	assign m_tdata = ycc_out;

`ifndef SYNTHESIS
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v1, v2, v3, v4, m_tvalid}))
		else $error("pipeline valid bits moved during a stall");

	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] >= 8'd16 && m_tdata[7:0] <= 8'd235))
		else $error("faded luma outside 16..235");

	a_chroma_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:8] >= 8'd16 && m_tdata[15:8] <= 8'd240 &&
			m_tdata[23:16] >= 8'd16 && m_tdata[23:16] <= 8'd240))
		else $error("faded chroma outside 16..240");
`endif

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the YUV alpha fade pixel pipeline, with randomised stream stalls.
module tb;
	import yafp_pkg::*;

	localparam int StallLimit  = 1000;
	localparam int DrainCycles = 12;
	localparam int PhaseItems  = 125;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // luma_in, cb_in, cr_in
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // luma_out, cb_out, cr_out

	ycc_t       pixel_q[$];
	ycc_t       faded_q[$];
	ycc_t       want_px;
	ycc_t       seen_px;
	logic [7:0] level_now    = 8'd255;
	logic       steady       = 1'b0;
	int         errors       = 0;
	int         quiet_cycles = 0;

	yuv_alpha_fade_pixel uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int q16_byte(input int q);
		int res;
		if (q < 0) begin
			res = 0;
		end else begin
			res = q >>> 16;
			if (res > 255) begin
				res = 255;
			end
		end
		return res;
	endfunction

	function automatic ycc_t fade_pixel(input ycc_t px, input logic [7:0] lvl);
		int   y, u, v, r, g, b;
		ycc_t res;
		y = int'(px.luma) - 16;
		u = int'(px.cb) - 128;
		v = int'(px.cr) - 128;
		r = q16_byte(76309 * y + 104597 * v);
		g = q16_byte(76309 * y - 25675 * u - 53279 * v);
		b = q16_byte(76309 * y + 132201 * u);
		r = (int'(lvl) * r) >>> 8;
		g = (int'(lvl) * g) >>> 8;
		b = (int'(lvl) * b) >>> 8;
		res.luma = 8'(q16_byte(16829 * r + 33039 * g + 6416 * b + (16 << 16)));
		res.cb   = 8'(q16_byte(-9714 * r - 19071 * g + 28784 * b + (128 << 16)));
		res.cr   = 8'(q16_byte(28784 * r - 24103 * g - 4681 * b + (128 << 16)));
		return res;
	endfunction

	task automatic add_pixel(input int l, input int cb, input int cr);
		ycc_t px;
		px.luma = 8'(l);
		px.cb   = 8'(cb);
		px.cr   = 8'(cr);
		pixel_q.push_back(px);
	endtask

	task automatic add_random_pixels(input int count);
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			if (kind < 60) begin
				add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
			end else if (kind < 90) begin
				add_pixel($urandom_range(235, 16), $urandom_range(240, 16), $urandom_range(240, 16));
			end else begin
				add_pixel($urandom_range(1) ? $urandom_range(255, 240) : $urandom_range(20),
					$urandom_range(1) ? 255 : 0, $urandom_range(1) ? 255 : 0);
			end
		end
	endtask

	task automatic write_level(input logic [7:0] lvl);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= lvl;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		level_now = lvl;
	endtask

	task automatic wait_idle;
		do @(posedge clk); while (pixel_q.size() != 0 || s_tvalid || faded_q.size() != 0);
	endtask

	// Stream driver: hold a beat until taken, insert random gaps between beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				faded_q.push_back(fade_pixel(ycc_t'(s_tdata), level_now));
			end
			if (!s_tvalid || s_tready) begin
				if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each beat with the oldest predicted pixel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_px = ycc_t'(m_tdata);
				if (faded_q.size() == 0) begin
					$error("unexpected output beat: %h", m_tdata);
					errors++;
				end else begin
					want_px = faded_q.pop_front();
					if (seen_px.luma !== want_px.luma) begin
						$error("luma_out: expected %0d, got %0d", want_px.luma, seen_px.luma);
						errors++;
					end
					if (seen_px.cb !== want_px.cb) begin
						$error("cb_out: expected %0d, got %0d", want_px.cb, seen_px.cb);
						errors++;
					end
					if (seen_px.cr !== want_px.cr) begin
						$error("cr_out: expected %0d, got %0d", want_px.cr, seen_px.cr);
						errors++;
					end
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 35);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= StallLimit) begin
				$display("tb: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [7:0] levels[6];
		levels = '{8'd255, 8'd1, 8'd128, 8'd0, 8'd0, 8'd0};
		levels[4] = 8'($urandom_range(254, 2));
		levels[5] = 8'($urandom_range(254, 2));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset fade level: extremes, nominal range edges and out-of-range samples.
		add_pixel(0, 0, 0);
		add_pixel(255, 255, 255);
		add_pixel(16, 128, 128);
		add_pixel(235, 128, 128);
		add_pixel(235, 16, 240);
		add_pixel(16, 240, 16);
		add_pixel(255, 0, 0);
		add_pixel(0, 255, 255);
		add_pixel(255, 255, 0);
		add_pixel(0, 0, 255);
		add_pixel(81, 90, 240);
		add_pixel(145, 54, 34);
		add_pixel(41, 240, 110);
		add_pixel(128, 128, 128);
		add_pixel(170, 85, 170);
		add_pixel(85, 170, 85);
		wait_idle();

		// Fade to black.
		write_level(8'd0);
		add_pixel(235, 128, 128);
		add_pixel(255, 0, 255);
		add_pixel(0, 255, 0);
		add_pixel(16, 128, 128);
		wait_idle();

		write_level(8'd255);
		add_pixel(255, 128, 255);
		add_pixel(0, 128, 0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			write_level(levels[p]);
			steady = (p == 2);
			add_random_pixels(PhaseItems);
			wait_idle();
		end
		steady = 1'b0;

		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && faded_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/yafp_pkg.sv
src/yafp_yuv2rgb.sv
src/yafp_fade.sv
src/yafp_rgb2yuv.sv
src/yuv_alpha_fade_pixel.sv
tb/tb.sv
